[sv/grke_pkg.sv]
// ----------------------------------------------------------------------------
// grke_pkg: shared types and constants for the GPIO remote key extractor
// Status codes, register indexes, field widths and header byte values.
// ----------------------------------------------------------------------------
`default_nettype none

package grke_pkg;

    localparam int GPIO_WIDTH_DEF = 24;
    localparam int GAP_W          = 10;
    localparam int CODE_W         = 32;
    localparam int BYTES_W        = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int GATHER_W       = 8;

    // result status, travels in m_tuser
    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_LOCKED = 2'd1,
        ST_REPEAT = 2'd2,
        ST_TICK   = 2'd3
    } status_t;

    // input kind, travels in s_tuser
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXTRACT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd4;

    localparam logic MODE_GENERIC  = 1'b0;
    localparam logic MODE_FOURBYTE = 1'b1;

    // four-byte header pairs, picked by sample bit 15
    localparam int          HDR_SEL_BIT = 15;
    localparam logic [7:0]  HDR_HI_B0   = 8'hc0;
    localparam logic [7:0]  HDR_HI_B1   = 8'h3f;
    localparam logic [7:0]  HDR_LO_B0   = 8'h40;
    localparam logic [7:0]  HDR_LO_B1   = 8'hbf;

    localparam logic [BYTES_W-1:0] NBYTES_NONE    = 3'd0;
    localparam logic [BYTES_W-1:0] NBYTES_GENERIC = 3'd1;
    localparam logic [BYTES_W-1:0] NBYTES_FOUR    = 3'd4;

    localparam int OUT_TDATA_W = ((CODE_W + BYTES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

[sv/gpio_remote_key_extractor_top.sv]
// ----------------------------------------------------------------------------
// gpio_remote_key_extractor_top: GPIO sample to remote key code converter
// Masks, lock test, key gather or four-byte code build, repeat suppression.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one word per cycle while s_tready is high:
//   s_tuser is the kind (0 GPIO sample, 1 time tick), s_tdata the raw
//   GPIO sample. Master stream returns exactly one word per input word,
//   in order: m_tuser is the status, m_tdata the code word and its byte count.
//   Config port (cfg_we/cfg_index/cfg_data) writes one register per edge;
//   write only while no words are in flight.
// Path: an accepted word is registered in the input stage, then its result is
//   registered in the output stage and shown on m_tvalid (two register stages).
// Throughput: one word per cycle while m_tready is high; the gather, lock
//   test, compare and countdown all sit in the single stage between the two registers.
// Stall: the output register holds its word while m_tready is low; the
//   input register keeps accepting until both stages are full.
// Reset: all configuration clears to zero, last code and the countdown
//   clear, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_remote_key_extractor_top #(
    parameter int GPIO_WIDTH = grke_pkg::GPIO_WIDTH_DEF,
    parameter int IN_TDATA_W = ((GPIO_WIDTH + 7) / 8) * 8,
    parameter int CFG_W      = (GPIO_WIDTH > grke_pkg::GAP_W) ? GPIO_WIDTH
                                                              : grke_pkg::GAP_W
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   s_tvalid,
    output      logic                                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]                  s_tdata,   // gpio_value
    input  wire logic                                   s_tuser,   // op

    output      logic                                   m_tvalid,
    input  wire logic                                   m_tready,
    // code_word [31:0], byte_count [34:32], zero fill above
    output      logic [grke_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output      logic [1:0]                             m_tuser,   // status

    input  wire logic                                   cfg_we,
    input  wire logic [grke_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]                       cfg_data
);

    localparam int CNT_W = $clog2(GPIO_WIDTH + 1);
    localparam int GW    = grke_pkg::GATHER_W;

    // configuration
    logic [GPIO_WIDTH-1:0]          extract_reg;
    logic [GPIO_WIDTH-1:0]          invert_reg;
    logic [GPIO_WIDTH-1:0]          lock_reg;
    logic [grke_pkg::GAP_W-1:0]     gap_ticks_reg;
    logic                           mode_reg;

    // state
    logic [grke_pkg::CODE_W-1:0]    last_code_reg;
    logic [grke_pkg::CODE_W-1:0]    last_code_next;
    logic [grke_pkg::GAP_W-1:0]     gap_rem_reg;
    logic [grke_pkg::GAP_W-1:0]     gap_rem_next;

    // input stage
    logic                           in_valid_reg;
    logic                           in_op_reg;
    logic [GPIO_WIDTH-1:0]          in_gpio_reg;

    // output stage
    logic                           out_valid_reg;
    grke_pkg::status_t              out_status_reg;
    grke_pkg::status_t              out_status_next;
    logic [grke_pkg::CODE_W-1:0]    out_code_reg;
    logic [grke_pkg::CODE_W-1:0]    out_code_next;
    logic [grke_pkg::BYTES_W-1:0]   out_bytes_reg;
    logic [grke_pkg::BYTES_W-1:0]   out_bytes_next;

    logic                           out_free;
    logic                           advance;

    logic [GPIO_WIDTH-1:0]          sample_v;
    logic                           locked;
    logic [CNT_W-1:0]               prefix [GPIO_WIDTH];
    logic [GW-1:0]                  gather;
    logic [grke_pkg::CODE_W-1:0]    masked_wide;
    logic [grke_pkg::CODE_W-1:0]    sample_wide;
    logic [7:0]                     key_byte;
    logic [grke_pkg::CODE_W-1:0]    code;
    logic                           match;
    logic                           suppress;

    // ---------------- handshake ----------------
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extract_reg   <= '0;
            invert_reg    <= '0;
            lock_reg      <= '0;
            gap_ticks_reg <= '0;
            mode_reg      <= grke_pkg::MODE_GENERIC;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                grke_pkg::REG_EXTRACT: extract_reg   <= cfg_data[GPIO_WIDTH-1:0];
                grke_pkg::REG_INVERT:  invert_reg    <= cfg_data[GPIO_WIDTH-1:0];
                grke_pkg::REG_LOCK:    lock_reg      <= cfg_data[GPIO_WIDTH-1:0];
                grke_pkg::REG_GAP:     gap_ticks_reg <= cfg_data[grke_pkg::GAP_W-1:0];
                grke_pkg::REG_MODE:    mode_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- input stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_gpio_reg <= s_tdata[GPIO_WIDTH-1:0];
        end
    end

    // ---------------- decode ----------------
    assign sample_v = in_gpio_reg ^ invert_reg;
    assign locked   = |(sample_v & lock_reg);

    // slot of each extract bit in the gathered code: count of mask bits below it
    always_comb
    begin
        for (int i = 0; i < GPIO_WIDTH; i++)
        begin
            prefix[i] = CNT_W'($countones(extract_reg &
                                          ((GPIO_WIDTH'(1) << i) - GPIO_WIDTH'(1))));
        end
    end

    // only the lowest eight selected bits land in the code
    always_comb
    begin
        gather = '0;
        for (int k = 0; k < GW; k++)
        begin
            for (int i = 0; i < GPIO_WIDTH; i++)
            begin
                if (extract_reg[i] && sample_v[i] && (prefix[i] == CNT_W'(k)))
                begin
                    gather[k] = 1'b1;
                end
            end
        end
    end

    assign masked_wide = grke_pkg::CODE_W'(sample_v & extract_reg);
    assign sample_wide = grke_pkg::CODE_W'(sample_v);
    assign key_byte    = masked_wide[23:16];

    always_comb
    begin
        if (mode_reg == grke_pkg::MODE_FOURBYTE)
        begin
            if (sample_wide[grke_pkg::HDR_SEL_BIT])
            begin
                code = {~key_byte, key_byte, grke_pkg::HDR_HI_B1, grke_pkg::HDR_HI_B0};
            end
            else
            begin
                code = {~key_byte, key_byte, grke_pkg::HDR_LO_B1, grke_pkg::HDR_LO_B0};
            end
            match = (code == last_code_reg);
        end
        else
        begin
            code  = grke_pkg::CODE_W'(gather);
            match = (code[7:0] == last_code_reg[7:0]);
        end
    end

    assign suppress = (gap_ticks_reg != '0) && match && (gap_rem_reg != '0);

    always_comb
    begin
        out_status_next = grke_pkg::ST_TICK;
        out_code_next   = '0;
        out_bytes_next  = grke_pkg::NBYTES_NONE;
        last_code_next  = last_code_reg;
        gap_rem_next    = gap_rem_reg;
        if (in_op_reg == grke_pkg::OP_TICK)
        begin
            out_status_next = grke_pkg::ST_TICK;
            if (gap_rem_reg != '0)
            begin
                gap_rem_next = gap_rem_reg - grke_pkg::GAP_W'(1);
            end
        end
        else if (locked)
        begin
            out_status_next = grke_pkg::ST_LOCKED;
        end
        else if (suppress)
        begin
            out_status_next = grke_pkg::ST_REPEAT;
        end
        else
        begin
            out_status_next = grke_pkg::ST_ACCEPT;
            out_code_next   = code;
            out_bytes_next  = (mode_reg == grke_pkg::MODE_FOURBYTE) ?
                              grke_pkg::NBYTES_FOUR : grke_pkg::NBYTES_GENERIC;
            last_code_next  = code;
            gap_rem_next    = gap_ticks_reg;
        end
    end

    // ---------------- state and output stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_code_reg <= '0;
            gap_rem_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                last_code_reg <= last_code_next;
                gap_rem_reg   <= gap_rem_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= out_status_next;
            out_code_reg   <= out_code_next;
            out_bytes_reg  <= out_bytes_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = grke_pkg::OUT_TDATA_W'({out_bytes_reg, out_code_reg});

endmodule

`default_nettype wire

[sv/grke_checker.sv]
// ----------------------------------------------------------------------------
// grke_checker: port-level checks for the GPIO remote key extractor
// Watches both streams for result consistency and hold under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module grke_checker #(
    parameter int GPIO_WIDTH = grke_pkg::GPIO_WIDTH_DEF,
    parameter int IN_TDATA_W = ((GPIO_WIDTH + 7) / 8) * 8
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic [IN_TDATA_W-1:0]               s_tdata,
    input wire logic                                s_tuser,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [grke_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input wire logic [1:0]                          m_tuser
);

    logic [31:0] cw;
    logic [2:0]  nb;

    assign cw = m_tdata[31:0];
    assign nb = m_tdata[34:32];

    // a waiting input word holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting input word changed");

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    // anything but an accepted key carries an empty code
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != grke_pkg::ST_ACCEPT) |-> (cw == '0) && (nb == '0))
        else $error("non-key result carries code data");

    // accepted generic key: one byte, upper bytes clear
    a_generic: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == grke_pkg::ST_ACCEPT) && (nb != grke_pkg::NBYTES_FOUR)
        |-> (nb == grke_pkg::NBYTES_GENERIC) && (cw[31:8] == '0))
        else $error("generic key malformed");

    // accepted four-byte key: valid header pair and complemented key byte
    a_four: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == grke_pkg::ST_ACCEPT) && (nb == grke_pkg::NBYTES_FOUR)
        |-> (cw[31:24] == ~cw[23:16]) &&
            (((cw[7:0] == grke_pkg::HDR_HI_B0) && (cw[15:8] == grke_pkg::HDR_HI_B1)) ||
             ((cw[7:0] == grke_pkg::HDR_LO_B0) && (cw[15:8] == grke_pkg::HDR_LO_B1))))
        else $error("four-byte key malformed");

endmodule

bind gpio_remote_key_extractor_top grke_checker #(
    .GPIO_WIDTH(GPIO_WIDTH),
    .IN_TDATA_W(IN_TDATA_W)
) u_grke_checker (.*);

`default_nettype wire
